/* rtl/dense_row_to_sparse_mod_p_unit_macros.svh */
// assertion macros for the dense row to sparse unit checker
// no dependencies
`ifndef DENSE_ROW_TO_SPARSE_MOD_P_UNIT_MACROS_SVH
`define DENSE_ROW_TO_SPARSE_MOD_P_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define DRS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define DRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/drs_pkg.sv */
// shared types and constants for the dense row to sparse unit
// no dependencies
package drs_pkg;
    localparam int ValueBits  = 64;
    localparam int ModBits    = 16;
    localparam int ColumnBits = 16;
    localparam logic [ModBits-1:0] ModulusReset = 16'd32003;

    localparam logic [0:0] RegModulus   = 1'b0;
    localparam logic [0:0] RegNormalize = 1'b1;

    typedef struct packed {
        logic [ValueBits-1:0] value;
        logic                 end_of_row;
    } drs_in_t;

    typedef struct packed {
        logic                  entry_valid;
        logic [ColumnBits-1:0] column;
        logic [ModBits-1:0]    scalar;
        logic                  row_done;
        logic                  row_empty;
        logic                  too_long;
    } drs_out_t;

    // front to back queue entry
    typedef struct packed {
        logic [ValueBits-1:0]  value;
        logic                  end_of_row;
        logic [ColumnBits-1:0] column;
        logic                  too_long;
    } drs_job_t;
endpackage

/* rtl/drs_if.sv */
// valid/ready channel interface carrying a payload struct
// no dependencies
interface drs_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/drs_front.sv */
// front part: accepts beats, tracks column counter and wrap, queues jobs
// depends on drs_pkg
module drs_front #(
    parameter int COLUMN_BITS = drs_pkg::ColumnBits
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  drs_pkg::drs_in_t    in_data,
    output logic                job_valid,
    input  logic                job_ready,
    output drs_pkg::drs_job_t   job_data
);
    import drs_pkg::*;

    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic                   ovf_reg, ovf_next;
    // two entry queue
    drs_job_t               q_reg [2];
    logic                   wp_reg, rp_reg;
    logic [1:0]             cnt_reg;
    logic                   push, pop;
    drs_job_t               job_new;

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job_data  = q_reg[rp_reg];

    always_comb
    begin
        job_new = '0;
        job_new.value      = in_data.value;
        job_new.end_of_row = in_data.end_of_row;
        job_new.too_long   = ovf_reg;
        job_new.column     = ColumnBits'(col_reg);
        col_next = col_reg;
        ovf_next = ovf_reg;
        if (in_data.end_of_row)
        begin
            col_next = '0;
            ovf_next = 1'b0;
        end
        else if (col_reg == {COLUMN_BITS{1'b1}})
        begin
            col_next = '0;
            ovf_next = 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            ovf_reg <= 1'b0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                col_reg <= col_next;
                ovf_reg <= ovf_next;
                wp_reg  <= ~wp_reg;
            end
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= job_new;
    end
endmodule

/* rtl/drs_back.sv */
// back part: serial 64-bit remainder, euclid inverse, scaling, output register
// depends on drs_pkg
module drs_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [drs_pkg::ModBits-1:0] modulus,
    input  logic                      normalize,
    input  logic                      job_valid,
    output logic                      job_ready,
    input  drs_pkg::drs_job_t         job_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output drs_pkg::drs_out_t         out_data
);
    import drs_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_REM, S_EVAL, S_DIV, S_EUC, S_FIX, S_MREM, S_OUT}
        state_t;

    state_t               state_reg;
    drs_job_t             job_reg;
    logic [6:0]           bit_reg;
    logic [ModBits:0]     rem_reg;
    logic [ModBits-1:0]   s_reg;
    logic                 seen_reg;
    logic [ModBits-1:0]   scale_reg;
    // euclid registers
    logic [ModBits-1:0]   r0_reg, r1_reg, q_reg, dr_reg;
    logic signed [ModBits+1:0] t0_reg, t1_reg;
    logic [4:0]           dbit_reg;
    logic [2*ModBits-1:0] prod_reg;
    logic [5:0]           pbit_reg;
    drs_out_t             out_reg;
    logic                 valid_reg;

    logic [ModBits:0]     rem_shift;
    logic [ModBits:0]     drem_shift;
    logic signed [2*ModBits+3:0] tq;

    assign job_ready = (state_reg == S_IDLE);
    assign out_valid = valid_reg;
    assign out_data  = out_reg;

    assign rem_shift  = {rem_reg[ModBits-1:0], job_reg.value[bit_reg[5:0]]};
    assign drem_shift = {dr_reg, r0_reg[dbit_reg[3:0]]};
    assign tq = $signed({2'b00, q_reg}) * t1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            seen_reg  <= 1'b0;
            scale_reg <= 16'd1;
        end
        else
        begin
            // a beat leaving in the output state is replaced there
            if (valid_reg && out_ready && state_reg != S_OUT)
                valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job_data;
                        bit_reg   <= 7'd63;
                        rem_reg   <= '0;
                        state_reg <= S_REM;
                    end
                end
                S_REM:
                begin
                    // restoring division, one dividend bit per cycle
                    if (rem_shift >= {1'b0, modulus})
                        rem_reg <= rem_shift - {1'b0, modulus};
                    else
                        rem_reg <= rem_shift;
                    if (bit_reg == 7'd0)
                        state_reg <= S_EVAL;
                    bit_reg <= bit_reg - 7'd1;
                end
                S_EVAL:
                begin
                    s_reg <= (modulus < 16'd2) ? '0 : rem_reg[ModBits-1:0];
                    if (modulus < 16'd2 || rem_reg == '0 || !normalize)
                        state_reg <= S_OUT;
                    else if (!seen_reg)
                    begin
                        r0_reg <= modulus;
                        r1_reg <= rem_reg[ModBits-1:0];
                        t0_reg <= '0;
                        t1_reg <= 18'sd1;
                        dr_reg <= '0;
                        q_reg  <= '0;
                        dbit_reg <= 5'd15;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        prod_reg <= scale_reg * rem_reg[ModBits-1:0];
                        rem_reg  <= '0;
                        pbit_reg <= 6'd31;
                        state_reg <= S_MREM;
                    end
                end
                S_DIV:
                begin
                    // r0 / r1, one quotient bit per cycle
                    if (drem_shift >= {1'b0, r1_reg})
                    begin
                        dr_reg <= 16'(drem_shift - {1'b0, r1_reg});
                        q_reg  <= {q_reg[ModBits-2:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg <= drem_shift[ModBits-1:0];
                        q_reg  <= {q_reg[ModBits-2:0], 1'b0};
                    end
                    if (dbit_reg == 5'd0)
                        state_reg <= S_EUC;
                    dbit_reg <= dbit_reg - 5'd1;
                end
                S_EUC:
                begin
                    r0_reg <= r1_reg;
                    r1_reg <= dr_reg;
                    t0_reg <= t1_reg;
                    t1_reg <= 18'(t0_reg - tq);
                    dr_reg <= '0;
                    q_reg  <= '0;
                    dbit_reg <= 5'd15;
                    if (dr_reg == '0)
                        state_reg <= S_FIX;
                    else
                        state_reg <= S_DIV;
                end
                S_FIX:
                begin
                    // t0 lies within (-m, m)
                    if (t0_reg < 0)
                        scale_reg <= 16'(t0_reg + $signed({2'b00, modulus}));
                    else
                        scale_reg <= t0_reg[ModBits-1:0];
                    s_reg <= 16'd1;
                    state_reg <= S_OUT;
                end
                S_MREM:
                begin
                    if ({rem_reg[ModBits-1:0], prod_reg[pbit_reg[4:0]]} >= {1'b0, modulus})
                        rem_reg <= {rem_reg[ModBits-1:0], prod_reg[pbit_reg[4:0]]}
                                   - {1'b0, modulus};
                    else
                        rem_reg <= {rem_reg[ModBits-1:0], prod_reg[pbit_reg[4:0]]};
                    if (pbit_reg == 6'd0)
                        state_reg <= S_OUT;
                    pbit_reg <= pbit_reg - 6'd1;
                end
                S_OUT:
                begin
                    if (!valid_reg || out_ready)
                    begin
                        logic nz;
                        logic [ModBits-1:0] sv;
                        nz = (s_reg != '0);
                        sv = (pbit_reg == 6'h3f && normalize && seen_reg && nz)
                             ? rem_reg[ModBits-1:0] : s_reg;
                        valid_reg <= 1'b1;
                        out_reg.entry_valid <= nz;
                        out_reg.column      <= nz ? job_reg.column : '0;
                        out_reg.scalar      <= nz ? sv : '0;
                        out_reg.row_done    <= job_reg.end_of_row;
                        out_reg.row_empty   <= job_reg.end_of_row && !(seen_reg || nz);
                        out_reg.too_long    <= job_reg.too_long;
                        if (job_reg.end_of_row)
                        begin
                            seen_reg  <= 1'b0;
                            scale_reg <= 16'd1;
                        end
                        else if (nz)
                            seen_reg <= 1'b1;
                        pbit_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/dense_row_to_sparse_mod_p_unit.sv */
// Dense row to sparse converter modulo a 16-bit modulus. Each beat passes
// through the back part in order: taking the job from the queue, the
// bit-serial remainder of the 64-bit value, picking the path and loading
// the output register; the first nonzero entry of a row in normalise mode
// adds the Euclid inverse (Euclid steps of one quotient bit per cycle, then
// a fold of the result), later entries add the product remainder. A stalled
// output holds the back part.
// A two-beat queue lets the front accept while the back works.
// depends on drs_pkg, drs_if, drs_front, drs_back
module dense_row_to_sparse_mod_p_unit #(
    parameter int COLUMN_BITS = drs_pkg::ColumnBits
) (
    input  logic                        clk,
    input  logic                        rst_n,
    drs_if.sink                         in_ch,
    drs_if.source                       out_ch,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [drs_pkg::ModBits-1:0] cfg_data
);
    import drs_pkg::*;

    logic [ModBits-1:0] modulus_reg;
    logic               normalize_reg;
    logic               job_valid, job_ready;
    drs_job_t           job_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= ModulusReset;
            normalize_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegModulus:   modulus_reg   <= cfg_data;
                RegNormalize: normalize_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    drs_front #(.COLUMN_BITS(COLUMN_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .job_valid(job_valid), .job_ready(job_ready), .job_data(job_data)
    );

    drs_back u_back (
        .clk(clk), .rst_n(rst_n),
        .modulus(modulus_reg), .normalize(normalize_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job_data(job_data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
    );
endmodule

/* rtl/drs_checker.sv */
// port-level checker for the dense row to sparse unit, bound to the top level
// depends on drs_pkg and the assertion macro header
`include "dense_row_to_sparse_mod_p_unit_macros.svh"
module drs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input drs_pkg::drs_out_t   out_data
);
    `DRS_ASSERT_IMP(a_empty_only_at_end, out_valid && out_data.row_empty,
        out_data.row_done && !out_data.entry_valid)
    `DRS_ASSERT_IMP(a_no_entry_zero, out_valid && !out_data.entry_valid,
        out_data.column == '0 && out_data.scalar == '0)
    `DRS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind dense_row_to_sparse_mod_p_unit drs_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
